// ===== design/jaq_pkg.sv =====
// jaq_pkg: shared types, constants and arithmetic helpers for the joint angle to quaternion unit
// no dependencies; imported by joint_angle_to_quaternion_unit and testbench
`timescale 1ns / 1ps
`default_nettype none

package jaq_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_ZERO  = 3'd0;
	localparam logic [2:0] REG_GAIN  = 3'd1;
	localparam logic [2:0] REG_AXIS  = 3'd2;
	localparam logic [2:0] REG_ROLL  = 3'd3;
	localparam logic [2:0] REG_PITCH = 3'd4;
	localparam logic [2:0] REG_YAW   = 3'd5;

	// axis codes, anything else acts as z
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;

	// mount angle selector codes
	localparam logic [1:0] MNT_ROLL  = 2'd0;
	localparam logic [1:0] MNT_PITCH = 2'd1;
	localparam logic [1:0] MNT_YAW   = 2'd2;

	// last step of the mount product sequence
	localparam logic [3:0] MUL_LAST = 4'd11;

	localparam logic signed [27:0] DEG2RAD_Q32     = 28'sd74961321;
	localparam logic signed [31:0] TWO_PI_Q28      = 32'sd1686629713;
	localparam logic signed [31:0] PI_Q28          = 32'sd843314856;
	localparam logic signed [31:0] HALF_PI_Q28     = 32'sd421657428;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// angle range reduction: 16 turns lift any half angle to non-negative
	localparam logic [36:0] TWO_PI_U  = 37'd1686629713;
	localparam logic [36:0] LIFT_U    = 37'd26986075408;

	typedef enum logic [2:0] {
		MNT_LOAD,
		MNT_CORD,
		MNT_MUL,
		MNT_SUM,
		MNT_IDLE
	} mnt_state_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [31:0] z;
	} cor_t;

	typedef struct packed {
		logic signed [31:0] z;
		logic               neg;
	} fold_t;

	function automatic logic [27:0] atan_q28(input logic [4:0] k);
		logic [27:0] a;
		case (k)
			5'd0:  a = 28'd210828714;
			5'd1:  a = 28'd124459457;
			5'd2:  a = 28'd65760959;
			5'd3:  a = 28'd33381290;
			5'd4:  a = 28'd16755422;
			5'd5:  a = 28'd8385879;
			5'd6:  a = 28'd4193963;
			5'd7:  a = 28'd2097109;
			5'd8:  a = 28'd1048571;
			5'd9:  a = 28'd524287;
			5'd10: a = 28'd262144;
			5'd11: a = 28'd131072;
			5'd12: a = 28'd65536;
			5'd13: a = 28'd32768;
			5'd14: a = 28'd16384;
			5'd15: a = 28'd8192;
			5'd16: a = 28'd4096;
			5'd17: a = 28'd2048;
			5'd18: a = 28'd1024;
			5'd19: a = 28'd512;
			5'd20: a = 28'd256;
			5'd21: a = 28'd128;
			5'd22: a = 28'd64;
			5'd23: a = 28'd32;
			5'd24: a = 28'd16;
			5'd25: a = 28'd8;
			5'd26: a = 28'd4;
			5'd27: a = 28'd2;
			5'd28: a = 28'd1;
			default: a = 28'd0;
		endcase
		return a;
	endfunction

	// one rotation-mode iteration with shift k
	function automatic cor_t cor_step(input cor_t c, input logic [4:0] k);
		cor_t r;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [31:0] at;
		dx = c.y >>> k;
		dy = c.x >>> k;
		at = signed'({4'b0000, atan_q28(k)});
		if (!c.z[31]) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - at;
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + at;
		end
		return r;
	endfunction

	// angle in [0, 2pi) to (-pi, pi], then folded into the right half plane
	function automatic fold_t fold_angle(input logic [30:0] r);
		fold_t f;
		logic signed [31:0] s;
		s = signed'({1'b0, r});
		if (s > PI_Q28)
			s = s - TWO_PI_Q28;
		f.neg = 1'b0;
		f.z = s;
		if (s > HALF_PI_Q28) begin
			f.z = s - PI_Q28;
			f.neg = 1'b1;
		end else if (s < -HALF_PI_Q28) begin
			f.z = s + PI_Q28;
			f.neg = 1'b1;
		end
		return f;
	endfunction

	// one restoring step of the modulo 2pi reduction
	function automatic logic [36:0] mod_step(input logic [36:0] u, input logic [2:0] j);
		logic [36:0] t;
		t = TWO_PI_U << j;
		return (u >= t) ? (u - t) : u;
	endfunction

	// Q2.30 product rounded back to Q.30
	function automatic logic signed [35:0] mul30(input logic signed [34:0] a,
		input logic signed [34:0] b);
		logic signed [69:0] p;
		p = a * b;
		p = p + (70'sd1 <<< 29);
		return p[65:30];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [37:0] v);
		logic [31:0] r;
		if (v > 38'sd2147483647)
			r = 32'h7fff_ffff;
		else if (v < -38'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/joint_angle_to_quaternion_unit.sv =====
// joint_angle_to_quaternion_unit: joint angle to mounted axis-angle quaternion, top level
// depends on jaq_pkg for types, constants and arithmetic helpers
`timescale 1ns / 1ps
`default_nettype none
// throughput: one item per cycle while the mount engine is idle and the output is not
// stalled, set by the fully unrolled joint CORDIC pipeline
// the mount quaternion is built by a sequential engine with one shared CORDIC and one
// multiplier after reset or any register write; no input is taken while it runs
// reset: configuration registers return to their reset values, pipeline empty, mount recomputed

module joint_angle_to_quaternion_unit
	import jaq_pkg::*;
#(
	parameter int CORDIC_STEPS = 24
) (
	input  wire                clk,
	input  wire                arst_n,
	// configuration
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [2:0]         cfg_index,
	input  wire  [31:0]        cfg_data,
	// joint samples
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  signed [31:0] joint_angle,
	// quaternions
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z,
	output logic signed [31:0] quat_w
);

	// stage map: 1 offset, 2 gain, 3 lift, 4..6 modulo, 7 fold, 8.. cordic, then
	// axis select, hamilton products, sums with saturation
	localparam int PRE  = 7;
	localparam int NST  = PRE + CORDIC_STEPS + 3;
	localparam int HS1  = PRE + CORDIC_STEPS + 1;
	localparam int HS2  = PRE + CORDIC_STEPS + 2;
	localparam int CNTW = $clog2(CORDIC_STEPS + 1);

	// configuration registers
	logic signed [31:0] zero_q;
	logic signed [15:0] gain_q;
	logic [1:0]         axis_q;
	logic signed [31:0] roll_q;
	logic signed [31:0] pitch_q;
	logic signed [31:0] yaw_q;
	logic               cfg_fire;

	// zero offset converted to radians, registered from zero_q and following it in the next cycle
	logic signed [32:0] zr_q;
	logic signed [59:0] zr_prod;

	// mount engine
	mnt_state_t          mst_q;
	mnt_state_t          mst_d;
	logic [1:0]          midx_q;
	logic [CNTW-1:0]     mcnt_q;
	logic [3:0]          mul_q;
	cor_t                mcor_q;
	logic                mneg_q;
	logic signed [33:0]  msin_q [3];
	logic signed [33:0]  mcos_q [3];
	logic signed [35:0]  mpr_q  [12];
	logic signed [34:0]  mx_q;
	logic signed [34:0]  my_q;
	logic signed [34:0]  mz_q;
	logic signed [34:0]  mw_q;
	logic signed [31:0]  mang;
	logic signed [32:0]  mhalf_sum;
	logic signed [31:0]  mhalf;
	logic signed [32:0]  mred;
	fold_t               mfold;
	logic signed [34:0]  opa;
	logic signed [34:0]  opb;
	logic                mbusy;

	// joint pipeline
	logic               vld_s [1:NST];
	logic               rdy   [1:NST];
	logic               in_fire;
	logic signed [33:0] diff_s1;
	logic signed [35:0] half_s2;
	logic signed [49:0] gprod;
	logic [36:0]        u_s3;
	logic [36:0]        u_s4;
	logic [36:0]        u_s5;
	logic [30:0]        r_s6;
	fold_t              jfold;
	cor_t               cor_s [0:CORDIC_STEPS];
	logic               neg_s [0:CORDIC_STEPS];
	logic signed [33:0] jsin;
	logic signed [33:0] jcos;
	logic signed [33:0] jx_s;
	logic signed [33:0] jy_s;
	logic signed [33:0] jz_s;
	logic signed [33:0] jc_s;
	logic signed [35:0] hp_s [16];
	logic signed [37:0] sx;
	logic signed [37:0] sy;
	logic signed [37:0] sz;
	logic signed [37:0] sw;
	logic signed [31:0] qx_s;
	logic signed [31:0] qy_s;
	logic signed [31:0] qz_s;
	logic signed [31:0] qw_s;

	// ---------------------------------------------------------------- configuration
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q  <= '0;
			gain_q  <= 16'sd4096;
			axis_q  <= 2'd2;
			roll_q  <= '0;
			pitch_q <= '0;
			yaw_q   <= '0;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_ZERO:  zero_q  <= cfg_data;
				REG_GAIN:  gain_q  <= cfg_data[15:0];
				REG_AXIS:  axis_q  <= cfg_data[1:0];
				REG_ROLL:  roll_q  <= cfg_data;
				REG_PITCH: pitch_q <= cfg_data;
				REG_YAW:   yaw_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// degrees to radians, rounded: Q10.22 * (pi/180 in Q.32) >> 26 gives Q.28
	always_comb begin
		zr_prod = zero_q * DEG2RAD_Q32;
		zr_prod = zr_prod + (60'sd1 <<< 25);
	end

	always_ff @(posedge clk) begin
		zr_q <= zr_prod[58:26];
	end

	// ---------------------------------------------------------------- mount engine
	// one shared cordic runs roll, pitch and yaw half angles in turn, then a
	// single multiplier walks the twelve products of the roll/pitch/yaw formula
	assign mbusy = (mst_q != MNT_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mst_q <= MNT_LOAD;
		else
			mst_q <= mst_d;
	end

	always_comb begin
		mst_d = mst_q;
		case (mst_q)
			MNT_LOAD: mst_d = MNT_CORD;
			MNT_CORD: begin
				if (mcnt_q == CNTW'(CORDIC_STEPS))
					mst_d = (midx_q == MNT_YAW) ? MNT_MUL : MNT_LOAD;
			end
			MNT_MUL: begin
				if (mul_q == MUL_LAST)
					mst_d = MNT_SUM;
			end
			MNT_SUM:  mst_d = MNT_IDLE;
			MNT_IDLE: mst_d = MNT_IDLE;
			default:  mst_d = MNT_LOAD;
		endcase
		// any register write restarts the mount computation
		if (cfg_fire)
			mst_d = MNT_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midx_q <= MNT_ROLL;
			mcnt_q <= '0;
			mul_q  <= '0;
		end else if (cfg_fire) begin
			midx_q <= MNT_ROLL;
			mcnt_q <= '0;
			mul_q  <= '0;
		end else begin
			case (mst_q)
				MNT_LOAD: mcnt_q <= '0;
				MNT_CORD: begin
					if (mcnt_q == CNTW'(CORDIC_STEPS)) begin
						midx_q <= midx_q + 2'd1;
						mul_q  <= '0;
					end else begin
						mcnt_q <= mcnt_q + CNTW'(1);
					end
				end
				MNT_MUL: mul_q <= mul_q + 4'd1;
				default: begin
				end
			endcase
		end
	end

	// half mount angle, floor((a + 1) / 2), then lifted into [0, 2pi)
	always_comb begin
		case (midx_q)
			MNT_ROLL:  mang = roll_q;
			MNT_PITCH: mang = pitch_q;
			default:   mang = yaw_q;
		endcase
		mhalf_sum = 33'(mang) + 33'sd1;
		mhalf     = mhalf_sum[32:1];
		mred      = 33'(mhalf);
		if (mhalf < 0)
			mred = mred + 33'(TWO_PI_Q28);
		mfold = fold_angle(mred[30:0]);
	end

	// operand selection for the product sequence
	always_comb begin
		case (mul_q)
			4'd0:    begin opa = 35'(msin_q[0]); opb = 35'(mcos_q[1]); end
			4'd1:    begin opa = 35'(mcos_q[0]); opb = 35'(msin_q[1]); end
			4'd2:    begin opa = 35'(mcos_q[0]); opb = 35'(mcos_q[1]); end
			4'd3:    begin opa = 35'(msin_q[0]); opb = 35'(msin_q[1]); end
			4'd4:    begin opa = 35'(mpr_q[0]);  opb = 35'(mcos_q[2]); end
			4'd5:    begin opa = 35'(mpr_q[1]);  opb = 35'(msin_q[2]); end
			4'd6:    begin opa = 35'(mpr_q[1]);  opb = 35'(mcos_q[2]); end
			4'd7:    begin opa = 35'(mpr_q[0]);  opb = 35'(msin_q[2]); end
			4'd8:    begin opa = 35'(mpr_q[2]);  opb = 35'(msin_q[2]); end
			4'd9:    begin opa = 35'(mpr_q[3]);  opb = 35'(mcos_q[2]); end
			4'd10:   begin opa = 35'(mpr_q[2]);  opb = 35'(mcos_q[2]); end
			default: begin opa = 35'(mpr_q[3]);  opb = 35'(msin_q[2]); end
		endcase
	end

	always_ff @(posedge clk) begin
		case (mst_q)
			MNT_LOAD: begin
				mcor_q.x <= CORDIC_GAIN_Q30;
				mcor_q.y <= '0;
				mcor_q.z <= mfold.z;
				mneg_q   <= mfold.neg;
			end
			MNT_CORD: begin
				if (mcnt_q == CNTW'(CORDIC_STEPS)) begin
					msin_q[midx_q] <= mneg_q ? -mcor_q.y : mcor_q.y;
					mcos_q[midx_q] <= mneg_q ? -mcor_q.x : mcor_q.x;
				end else begin
					mcor_q <= cor_step(mcor_q, 5'(mcnt_q));
				end
			end
			MNT_MUL: mpr_q[mul_q] <= mul30(opa, opb);
			MNT_SUM: begin
				mx_q <= 35'(37'(mpr_q[4])  - 37'(mpr_q[5]));
				my_q <= 35'(37'(mpr_q[6])  + 37'(mpr_q[7]));
				mz_q <= 35'(37'(mpr_q[8])  - 37'(mpr_q[9]));
				mw_q <= 35'(37'(mpr_q[10]) + 37'(mpr_q[11]));
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- joint pipeline
	// elastic pipeline: a stage takes new data when it is empty or its data moves on,
	// so bubbles collapse and a waiting result blocks the input only once every stage is full
	assign rdy[NST]  = !vld_s[NST] || out_ready;
	genvar gk;
	generate
		for (gk = 1; gk < NST; gk++) begin : g_rdy
			assign rdy[gk] = !vld_s[gk] || rdy[gk + 1];
		end
	endgenerate

	assign in_ready = rdy[1] && !mbusy;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++)
				vld_s[k] <= 1'b0;
		end else begin
			if (rdy[1])
				vld_s[1] <= in_fire;
			for (int k = 2; k <= NST; k++) begin
				if (rdy[k])
					vld_s[k] <= vld_s[k - 1];
			end
		end
	end

	// stage 1: subtract the zero offset
	always_ff @(posedge clk) begin
		if (rdy[1])
			diff_s1 <= 34'(joint_angle) - 34'(zr_q);
	end

	// stage 2: gain and halving in one rounded shift, Q.28 * Q4.12 >> 13
	always_comb begin
		gprod = diff_s1 * gain_q;
		gprod = gprod + 50'sd4096;
	end

	always_ff @(posedge clk) begin
		if (rdy[2])
			half_s2 <= gprod[48:13];
	end

	// stages 3 to 6: lift by whole turns, then restoring modulo 2pi
	always_ff @(posedge clk) begin
		if (rdy[3])
			u_s3 <= 37'(half_s2) + LIFT_U;
		if (rdy[4])
			u_s4 <= mod_step(mod_step(u_s3, 3'd5), 3'd4);
		if (rdy[5])
			u_s5 <= mod_step(mod_step(u_s4, 3'd3), 3'd2);
		if (rdy[6]) begin
			r_s6 <= 31'(mod_step(mod_step(u_s5, 3'd1), 3'd0));
		end
	end

	// stage 7: fold into the cordic range and seed the rotation
	assign jfold = fold_angle(r_s6);

	always_ff @(posedge clk) begin
		if (rdy[PRE]) begin
			cor_s[0].x <= CORDIC_GAIN_Q30;
			cor_s[0].y <= '0;
			cor_s[0].z <= jfold.z;
			neg_s[0]   <= jfold.neg;
		end
	end

	// one cordic iteration per stage
	generate
		for (gk = 1; gk <= CORDIC_STEPS; gk++) begin : g_cor
			always_ff @(posedge clk) begin
				if (rdy[PRE + gk]) begin
					cor_s[gk] <= cor_step(cor_s[gk - 1], 5'(gk - 1));
					neg_s[gk] <= neg_s[gk - 1];
				end
			end
		end
	endgenerate

	// axis select after undoing the half-plane fold
	assign jsin = neg_s[CORDIC_STEPS] ? -cor_s[CORDIC_STEPS].y : cor_s[CORDIC_STEPS].y;
	assign jcos = neg_s[CORDIC_STEPS] ? -cor_s[CORDIC_STEPS].x : cor_s[CORDIC_STEPS].x;

	always_ff @(posedge clk) begin
		if (rdy[HS1]) begin
			jc_s <= jcos;
			jx_s <= (axis_q == AXIS_X) ? jsin : '0;
			jy_s <= (axis_q == AXIS_Y) ? jsin : '0;
			jz_s <= (axis_q != AXIS_X && axis_q != AXIS_Y) ? jsin : '0;
		end
	end

	// hamilton product q = mount * joint, each term rounded to Q.30
	always_ff @(posedge clk) begin
		if (rdy[HS2]) begin
			hp_s[0]  <= mul30(mw_q, 35'(jx_s));
			hp_s[1]  <= mul30(mx_q, 35'(jc_s));
			hp_s[2]  <= mul30(my_q, 35'(jz_s));
			hp_s[3]  <= mul30(mz_q, 35'(jy_s));
			hp_s[4]  <= mul30(mw_q, 35'(jy_s));
			hp_s[5]  <= mul30(mx_q, 35'(jz_s));
			hp_s[6]  <= mul30(my_q, 35'(jc_s));
			hp_s[7]  <= mul30(mz_q, 35'(jx_s));
			hp_s[8]  <= mul30(mw_q, 35'(jz_s));
			hp_s[9]  <= mul30(mx_q, 35'(jy_s));
			hp_s[10] <= mul30(my_q, 35'(jx_s));
			hp_s[11] <= mul30(mz_q, 35'(jc_s));
			hp_s[12] <= mul30(mw_q, 35'(jc_s));
			hp_s[13] <= mul30(mx_q, 35'(jx_s));
			hp_s[14] <= mul30(my_q, 35'(jy_s));
			hp_s[15] <= mul30(mz_q, 35'(jz_s));
		end
	end

	always_comb begin
		sx = 38'(hp_s[0])  + 38'(hp_s[1])  + 38'(hp_s[2])  - 38'(hp_s[3]);
		sy = 38'(hp_s[4])  - 38'(hp_s[5])  + 38'(hp_s[6])  + 38'(hp_s[7]);
		sz = 38'(hp_s[8])  + 38'(hp_s[9])  - 38'(hp_s[10]) + 38'(hp_s[11]);
		sw = 38'(hp_s[12]) - 38'(hp_s[13]) - 38'(hp_s[14]) - 38'(hp_s[15]);
	end

	// last stage is the output register
	always_ff @(posedge clk) begin
		if (rdy[NST]) begin
			qx_s <= sat32(sx);
			qy_s <= sat32(sy);
			qz_s <= sat32(sz);
			qw_s <= sat32(sw);
		end
	end

	assign out_valid = vld_s[NST];
	assign quat_x    = qx_s;
	assign quat_y    = qy_s;
	assign quat_z    = qz_s;
	assign quat_w    = qw_s;

	// ---------------------------------------------------------------- checks
	a_no_input_while_mount_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mbusy |-> !in_ready)
		else $error("input taken while mount quaternion is being computed");

	a_result_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NST] && !out_ready) |=> vld_s[NST])
		else $error("pending result dropped");

	a_write_restarts_mount: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> (mst_q == MNT_LOAD))
		else $error("register write did not restart mount computation");

	a_mul_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mst_q == MNT_MUL) |-> (mul_q <= MUL_LAST))
		else $error("mount product step out of range");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench: self-checking regression for joint_angle_to_quaternion_unit
// depends on jaq_pkg and the unit; predicts each quaternion from its own fixed-point model
`timescale 1ns / 1ps
`default_nettype none

module testbench
	import jaq_pkg::*;
();

	localparam int STEPS = 24;

	typedef struct {
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic signed [31:0] qz;
		logic signed [31:0] qw;
	} quat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic cfg_ready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] joint_angle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] quat_x, quat_y, quat_z, quat_w;

	joint_angle_to_quaternion_unit #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .joint_angle(joint_angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor's copy of the registers
	logic [31:0] zero_deg = 32'd0;
	logic [15:0] gain = 16'd4096;
	logic [1:0] axis = 2'd2;
	logic [31:0] roll = 32'd0, pitch = 32'd0, yaw = 32'd0;

	logic signed [31:0] angle_q[$];
	quat_t quat_q[$];
	int errors = 0;
	bit long_hold = 1'b0;

	// floor shift on 64-bit signed
	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint rmul30(longint a, longint b);
		return floor_shr(a * b + (64'sd1 <<< 29), 30);
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return 32'(v);
	endfunction

	function automatic longint atan_entry(int k);
		longint tab[32] = '{210828714, 124459457, 65760959, 33381290, 16755422,
			8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
			32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
			4, 2, 1, 0, 0, 0};
		return tab[k & 31];
	endfunction

	// cordic sine/cosine of a Q.28 angle, results in Q2.30
	task automatic sin_cos(input longint ang, output longint s, output longint c);
		longint r, x, y, z, dx, dy;
		bit flip;
		r = ang % 64'sd1686629713;
		x = 652032874;
		y = 0;
		flip = 1'b0;
		if (r < 0) r += 1686629713;
		if (r > 843314856) r -= 1686629713;
		if (r > 421657428) begin
			r -= 843314856; flip = 1'b1;
		end else if (r < -421657428) begin
			r += 843314856; flip = 1'b1;
		end
		z = r;
		for (int i = 0; i < STEPS; i++) begin
			dx = floor_shr(y, i & 31);
			dy = floor_shr(x, i & 31);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_entry(i);
			end else begin
				x += dx; y -= dy; z += atan_entry(i);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		s = y;
		c = x;
	endtask

	task automatic predict_quat(input logic signed [31:0] jp, output quat_t q);
		longint zr, half, js, jc, jx, jy, jz, sr, cr, sp, cp, sy, cy;
		longint mx, my, mz, mw;
		zr = floor_shr(longint'($signed(zero_deg)) * 74961321 + (64'sd1 <<< 25), 26);
		half = floor_shr((longint'(jp) - zr) * longint'($signed(gain)) + 4096, 13);
		sin_cos(half, js, jc);
		jx = 0; jy = 0; jz = 0;
		if (axis == AXIS_X) jx = js;
		else if (axis == AXIS_Y) jy = js;
		else jz = js;
		sin_cos(floor_shr(longint'($signed(roll)) + 1, 1), sr, cr);
		sin_cos(floor_shr(longint'($signed(pitch)) + 1, 1), sp, cp);
		sin_cos(floor_shr(longint'($signed(yaw)) + 1, 1), sy, cy);
		mx = rmul30(rmul30(sr, cp), cy) - rmul30(rmul30(cr, sp), sy);
		my = rmul30(rmul30(cr, sp), cy) + rmul30(rmul30(sr, cp), sy);
		mz = rmul30(rmul30(cr, cp), sy) - rmul30(rmul30(sr, sp), cy);
		mw = rmul30(rmul30(cr, cp), cy) + rmul30(rmul30(sr, sp), sy);
		q.qx = clamp32(rmul30(mw, jx) + rmul30(mx, jc) + rmul30(my, jz) - rmul30(mz, jy));
		q.qy = clamp32(rmul30(mw, jy) - rmul30(mx, jz) + rmul30(my, jc) + rmul30(mz, jx));
		q.qz = clamp32(rmul30(mw, jz) + rmul30(mx, jy) - rmul30(my, jx) + rmul30(mz, jc));
		q.qw = clamp32(rmul30(mw, jc) - rmul30(mx, jx) - rmul30(my, jy) - rmul30(mz, jz));
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// configuration write, issued once the joint pipe has drained; the mount engine may still be busy
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ZERO: zero_deg = val;
			REG_GAIN: gain = val[15:0];
			REG_AXIS: axis = val[1:0];
			REG_ROLL: roll = val;
			REG_PITCH: pitch = val;
			REG_YAW: yaw = val;
			default: ;
		endcase
	endtask

	// wait until all quaternions are back and the pipe is empty
	task automatic drain();
		while (angle_q.size() != 0 || quat_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h8000_0000 | $urandom_range(0, 15);
			2: return 32'h7fff_fff0 | $urandom_range(0, 15);
			default: return $urandom_range(0, 32'h7fff_ffff) - 32'sh4000_0000;
		endcase
	endfunction

	// driver: one transfer per queued angle, random gap after each
	int in_gap = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			quat_t q;
			predict_quat(joint_angle, q);
			quat_q.insert(quat_q.size(), q);
			void'(angle_q.pop_front());
			in_gap = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0) in_gap = 0;
		end
		if (!in_valid || in_ready) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (angle_q.size() != 0) begin
				in_valid <= 1'b1;
				joint_angle <= angle_q[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold, counted in its own process
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (long_hold && !hold_done) begin
			hold_left <= 300;
			hold_done <= 1'b1;
		end
	end

	// monitor: compares each quaternion transfer with the oldest prediction
	int out_gap = 0;
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (quat_q.size() == 0) begin
				report("unexpected quaternion", quat_x, 32'h0);
			end else begin
				quat_t w;
				w = quat_q.pop_front();
				if (quat_x !== w.qx) report("quat_x", quat_x, w.qx);
				if (quat_y !== w.qy) report("quat_y", quat_y, w.qy);
				if (quat_z !== w.qz) report("quat_z", quat_z, w.qz);
				if (quat_w !== w.qw) report("quat_w", quat_w, w.qw);
			end
			out_gap = $urandom_range(0, 7);
			if ($urandom_range(0, 2) == 0) out_gap = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// stimulus
	initial begin
		logic [31:0] corner[] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
			32'd1, 32'd421657428, -32'sd421657428, 32'd843314856, -32'sd843314856,
			32'd1686629713, 32'h5555_5555, 32'haaaa_aaaa};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// directed: reset settings, then corners of the registers
		foreach (corner[i]) angle_q.insert(angle_q.size(), corner[i]);
		drain();
		write_reg(REG_AXIS, 32'd3); // axis code three acts as z
		write_reg(REG_GAIN, 32'h0000_7fff);
		write_reg(REG_ZERO, 32'h7fff_ffff);
		foreach (corner[i]) angle_q.insert(angle_q.size(), corner[i]);
		drain();
		write_reg(REG_AXIS, {30'd0, AXIS_X});
		write_reg(REG_GAIN, 32'hffff_8000);
		write_reg(REG_ZERO, 32'h8000_0000);
		write_reg(REG_ROLL, 32'h7fff_ffff);
		write_reg(REG_PITCH, 32'h8000_0000);
		write_reg(REG_YAW, 32'd843314856);
		write_reg(3'd7, 32'hdead_beef); // out-of-range index is ignored
		foreach (corner[i]) angle_q.insert(angle_q.size(), corner[i]);
		drain();
		// random phases with random settings
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_ZERO, $urandom());
			write_reg(REG_GAIN, ($urandom_range(0, 1)) ? $urandom() : 32'd4096);
			write_reg(REG_AXIS, $urandom_range(0, 3));
			write_reg(REG_ROLL, $urandom());
			write_reg(REG_PITCH, $urandom());
			write_reg(REG_YAW, $urandom());
			if (ph == 4) long_hold = 1'b1;
			for (int k = 0; k < 120; k++) angle_q.insert(angle_q.size(), rand_angle());
			drain();
		end
		if (errors == 0)
			$display("joint_angle_to_quaternion_unit regression: pass");
		else
			$display("joint_angle_to_quaternion_unit regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("joint_angle_to_quaternion_unit regression: fail");
		$finish;
	end
endmodule

`default_nettype wire

// ===== sim.f =====
design/jaq_pkg.sv
design/joint_angle_to_quaternion_unit.sv
dv/testbench.sv
